[rtl/slsr_pkg.sv]
// Shared types and constants for the streaming literal search-and-replace block.
// No dependencies; every other file in rtl/ imports this package.
package slsr_pkg;

    // Largest supported pattern and replacement, in bytes.
    localparam int PATTERN_MAX_C = 8;
    localparam int REPL_MAX_C    = 8;

    // Width of a job's source byte vector (sized for the largest pattern).
    localparam int SRC_W = PATTERN_MAX_C * 8;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       end_marker;
    } t_out_item;

    // One request's work for the back end: emit lit_cnt bytes from src, then the
    // replacement if repl is set. last marks the request that ends the stream.
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [3:0]       lit_cnt;
        logic             repl;
        logic             last;
    } t_job;

endpackage

[rtl/slsr_front.sv]
// Front end: accepts input requests, runs the prefix search against the pattern
// and keeps the pending buffer. Depends on slsr_pkg.
module slsr_front #(
    parameter int PATTERN_MAX = slsr_pkg::PATTERN_MAX_C
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_pat,
    input  logic [3:0]          i_plen,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  slsr_pkg::t_in_item  i_in_item,
    input  logic                i_full,
    output logic                o_push,
    output slsr_pkg::t_job      o_job
);
    import slsr_pkg::*;

    localparam int PD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int CW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int VW = PATTERN_MAX * 8;

    logic [7:0]       r_pend [PD];
    logic [7:0]       n_pend [PD];
    logic [CW-1:0]    r_pcnt;

    logic [3:0]       w_plen;
    logic [3:0]       w_pc;
    logic [3:0]       w_ntot;
    logic [3:0]       w_base;
    logic             w_flush;
    logic [VW-1:0]    w_srcv;
    logic [VW-1:0]    w_shift;
    logic [PATTERN_MAX-1:0] w_hit;
    logic [3:0]       w_ssel;
    logic             w_found;
    logic             w_full_match;
    logic [3:0]       w_kept;
    logic             w_last;

    assign w_plen  = (i_plen > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : i_plen;
    assign w_pc    = 4'(r_pcnt);
    assign w_ntot  = w_pc + 4'd1;
    assign w_flush = (w_pc >= w_plen);
    // After a flush of stale bytes only the new byte is searched.
    assign w_base  = w_flush ? w_pc : 4'd0;
    assign w_last  = i_in_item.stream_end;

    // Source bytes: pending bytes followed by the new byte.
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_src
        if (g < PATTERN_MAX - 1) begin : g_pend
            assign w_srcv[8*g +: 8] = (4'(g) < w_pc) ? r_pend[g] : i_in_item.data_byte;
        end else begin : g_new
            assign w_srcv[8*g +: 8] = i_in_item.data_byte;
        end
    end

    // A start offset hits when every byte from it to the end equals the pattern prefix.
    always_comb begin
        w_hit = '0;
        for (int s = 0; s < PATTERN_MAX; s++) begin
            w_hit[s] = (w_plen != 4'd0) && (4'(s) >= w_base) && (4'(s) < w_ntot);
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (s + i < PATTERN_MAX) begin
                    if ((4'(s + i) < w_ntot) &&
                        (w_srcv[8*(s+i) +: 8] != i_pat[8*i +: 8])) begin
                        w_hit[s] = 1'b0;
                    end
                end
            end
        end
    end

    // Lowest hitting offset; everything before it leaves as literal bytes.
    always_comb begin
        w_ssel  = w_ntot;
        w_found = 1'b0;
        for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
            if (w_hit[s]) begin
                w_ssel  = 4'(s);
                w_found = 1'b1;
            end
        end
    end

    assign w_full_match = w_found && ((w_ntot - w_ssel) == w_plen);
    assign w_kept       = (w_full_match || w_last) ? 4'd0 : (w_ntot - w_ssel);
    assign w_shift      = w_srcv >> {w_ssel, 3'b000};

    always_comb begin
        for (int i = 0; i < PD; i++) begin
            n_pend[i] = w_shift[8*i +: 8];
        end
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_job.src     = SRC_W'(w_srcv);
        o_job.lit_cnt = (w_full_match || !w_last) ? w_ssel : w_ntot;
        o_job.repl    = w_full_match;
        o_job.last    = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
        end else if (o_push) begin
            r_pcnt <= w_kept[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_pend <= n_pend;
        end
    end

endmodule

[rtl/slsr_queue.sv]
// Short job queue that decouples the front end from the back end.
// Depends on slsr_pkg for the job type and depth.
module slsr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slsr_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output slsr_pkg::t_job  o_head
);
    import slsr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue read while empty");

endmodule

[rtl/slsr_back.sv]
// Back end: plays out each queued job one result byte per cycle into an output
// register, unless the output stalls. Depends on slsr_pkg.
module slsr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [63:0]         i_repl,
    input  logic [3:0]          i_rlen,
    input  logic                i_head_valid,
    input  slsr_pkg::t_job      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output slsr_pkg::t_out_item o_out_item
);
    import slsr_pkg::*;

    logic [3:0]  r_idx;
    logic [3:0]  n_idx;
    logic        r_out_valid;
    logic        n_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    logic [3:0]  w_rlen;
    logic [4:0]  w_total;
    logic        w_take;
    logic        w_final;
    logic [3:0]  w_ridx;

    assign w_rlen  = (i_rlen > 4'(REPL_MAX_C)) ? 4'(REPL_MAX_C) : i_rlen;
    assign w_total = {1'b0, i_head.lit_cnt} + (i_head.repl ? {1'b0, w_rlen} : 5'd0);
    assign w_take  = i_head_valid && (!r_out_valid || i_out_ready);
    assign w_final = ({1'b0, r_idx} + 5'd1 == w_total);
    assign w_ridx  = r_idx - i_head.lit_cnt;

    assign o_pop = w_take && ((w_total == 5'd0) || w_final);

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        if (w_take && (w_total != 5'd0)) begin
            n_out_valid = 1'b1;
            if (r_idx < i_head.lit_cnt) begin
                n_out_item.out_byte = i_head.src[8*r_idx[2:0] +: 8];
            end else begin
                n_out_item.out_byte = i_repl[8*w_ridx[2:0] +: 8];
            end
            n_out_item.run_last   = w_final;
            n_out_item.end_marker = w_final && i_head.last;
            n_idx = w_final ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.end_marker) |-> r_out_item.run_last)
        else $error("end marker without run_last");

    a_job_held_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 4'd0) |-> i_head_valid)
        else $error("job vanished in the middle of its run");

    a_pop_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (w_total != 5'd0)) |=> (r_out_valid && r_out_item.run_last))
        else $error("job retired without its last result");

endmodule

[rtl/streaming_literal_search_replace.sv]
// Top level of the streaming literal search-and-replace block: configuration
// registers and the front end, job queue and back end. Depends on slsr_pkg.
//
//   Channel   Direction  Handshake                   Payload
//   cfg       in         i_cfg_we                    i_cfg_idx, i_cfg_data
//   in        in         i_in_valid / o_in_ready     i_in_item (t_in_item)
//   out       out        o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// The front end takes one request per cycle while the two-entry job queue has
// room. The back end sends one result byte per cycle while the output is not
// stalled. The first result of a request passes through the job queue and then
// the output register; earlier jobs in the queue or a stalled output can hold it.
// Reset is synchronous and active low; it clears the configuration registers, the
// queue, the pending count and the back end's index and output valid. A stalled
// output holds the back end, and the queue fills before o_in_ready drops.
module streaming_literal_search_replace #(
    parameter int PATTERN_MAX = slsr_pkg::PATTERN_MAX_C
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [slsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [slsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  slsr_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output slsr_pkg::t_out_item                o_out_item
);
    import slsr_pkg::*;

    // Configuration registers. The user must change them only while the block is idle;
    // the block does not enforce this, and the front and back ends read them directly.
    logic [63:0] r_pat;
    logic [3:0]  r_plen;
    logic [63:0] r_repl;
    logic [3:0]  r_rlen;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_head_valid;
    t_job  w_job;
    t_job  w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= '0;
            r_repl <= '0;
            r_rlen <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PATTERN_BYTES:      r_pat  <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen <= i_cfg_data[3:0];
                CFG_REPLACEMENT_BYTES:  r_repl <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The front end decides, for each request, which buffered bytes leave as
    // literals and whether the replacement follows; it keeps the rest pending.
    slsr_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pat      (r_pat),
        .i_plen     (r_plen),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job)
    );

    // The queue lets the front end keep accepting while results drain.
    slsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    // The back end expands each job into result bytes through an output register.
    slsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_repl       (r_repl),
        .i_rlen       (r_rlen),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
